@@ sv/eic_pkg.sv @@
// Shared constants, codes and types of the external interrupt edge controller.
package eic_pkg;

	localparam int NUM_LINES_DEF = 16;
	localparam int LINE_W        = 16;
	localparam int PSEL_W        = 32;
	localparam int SEL_W         = 2;
	localparam int NUM_PORTS     = 4;
	localparam int VEC_W         = 7;
	localparam int MODE_W        = 2;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 32;

	localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_PORT_SELECT    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RISING_ENABLE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FALLING_ENABLE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INTERRUPT_MASK = 2'd3;

	// Step control that every lane sees
	typedef struct packed {
		logic adv;
		logic sample;
		logic clear;
	} lane_ctrl_t;

endpackage

@@ sv/eic_intf.sv @@
// Handshake channels of the external interrupt edge controller.
interface eic_cmd_if import eic_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [LINE_W-1:0] port_a_pins;
	logic [LINE_W-1:0] port_b_pins;
	logic [LINE_W-1:0] port_c_pins;
	logic [LINE_W-1:0] port_d_pins;
	logic [LINE_W-1:0] clear_bits;

	modport source (output valid, mode, port_a_pins, port_b_pins, port_c_pins,
		port_d_pins, clear_bits, input ready);
	modport sink (input valid, mode, port_a_pins, port_b_pins, port_c_pins,
		port_d_pins, clear_bits, output ready);
endinterface

interface eic_rsp_if import eic_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [LINE_W-1:0] pending_flags;
	logic [VEC_W-1:0]  irq_vectors;

	modport source (output valid, pending_flags, irq_vectors, input ready);
	modport sink (input valid, pending_flags, irq_vectors, output ready);
endinterface

interface eic_cfg_if import eic_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ sv/eic_lane.sv @@
// One interrupt line: source select, edge detect and pending bit.
module eic_lane import eic_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lane_ctrl_t           ctrl,
	input  logic [SEL_W-1:0]     sel,
	input  logic [NUM_PORTS-1:0] pins,
	input  logic                 rise_en,
	input  logic                 fall_en,
	input  logic                 clr,
	output logic                 pend_nxt
);

	logic prev_q;
	logic pend_q;
	logic cur;
	logic hit;

	assign cur = pins[sel];
	assign hit = (cur & ~prev_q & rise_en) | (~cur & prev_q & fall_en);

	always_comb begin
		if (ctrl.sample) begin
			pend_nxt = pend_q | hit;
		end else if (ctrl.clear) begin
			pend_nxt = pend_q & ~clr;
		end else begin
			pend_nxt = pend_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= 1'b0;
			pend_q <= 1'b0;
		end else if (ctrl.adv) begin
			pend_q <= pend_nxt;
			// keep the level only on a sample tick
			if (ctrl.sample) begin
				prev_q <= cur;
			end
		end
	end

endmodule

@@ sv/eic_merge.sv @@
// Merge of lane pending bits into grouped interrupt vectors.
module eic_merge import eic_pkg::*; (
	input  logic [LINE_W-1:0] pend,
	input  logic [LINE_W-1:0] mask,
	output logic [VEC_W-1:0]  vec
);

	logic [LINE_W-1:0] act;

	assign act    = pend & mask;
	assign vec[4:0] = act[4:0];
	assign vec[5] = |act[9:5];
	assign vec[6] = |act[15:10];

endmodule

@@ sv/external_interrupt_edge_controller.sv @@
// Top level of the sixteen-line external interrupt edge controller.
//
// Usage:
//   cfg  - register writes: index 0 port_select (two bits per line, 0=A..3=D),
//          1 rising_enable, 2 falling_enable, 3 interrupt_mask. Always ready;
//          write only while no command beat is in flight.
//   cmd  - one beat per step: mode 0 samples the four ports and detects edges,
//          mode 1 clears the pending bits set in clear_bits, mode 2 (and 3)
//          only reads the pending bits.
//   rsp  - one beat per command: pending_flags after the step and irq_vectors
//          (lines 0..4 each, lines 5..9 ORed, lines 10..15 ORed, masked).
// Each line is its own lane; the lanes update in parallel and a merge stage
// groups their pending bits into vectors.
// A rsp beat appears in the cycle after its cmd beat is accepted. Throughput:
// one beat per cycle when rsp is not stalled, set by the single rsp register.
// Stall: while rsp is held, cmd stays ready only if the held beat leaves in
// the same cycle; otherwise cmd backs up and no state advances.
// Reset: levels, pending bits, config and rsp valid clear, rsp data does not;
// a line high on the first sample after reset thus counts as a rising edge.
module external_interrupt_edge_controller import eic_pkg::*; #(
	parameter int NUM_LINES = NUM_LINES_DEF
) (
	input logic        clk,
	input logic        arst_n,
	eic_cfg_if.sink    cfg,
	eic_cmd_if.sink    cmd,
	eic_rsp_if.source  rsp
);

	// configuration registers
	logic [PSEL_W-1:0] port_select_q;
	logic [LINE_W-1:0] rising_enable_q;
	logic [LINE_W-1:0] falling_enable_q;
	logic [LINE_W-1:0] interrupt_mask_q;

	// output register
	logic              rsp_valid_q;
	logic [LINE_W-1:0] pending_q;
	logic [VEC_W-1:0]  vec_q;

	lane_ctrl_t        ctrl;
	logic [LINE_W-1:0] pend_nxt;
	logic [VEC_W-1:0]  vec_nxt;
	logic              cmd_fire;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port_select_q    <= '0;
			rising_enable_q  <= '0;
			falling_enable_q <= '0;
			interrupt_mask_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_PORT_SELECT:    port_select_q    <= cfg.data;
				REG_RISING_ENABLE:  rising_enable_q  <= cfg.data[LINE_W-1:0];
				REG_FALLING_ENABLE: falling_enable_q <= cfg.data[LINE_W-1:0];
				REG_INTERRUPT_MASK: interrupt_mask_q <= cfg.data[LINE_W-1:0];
				default: ;
			endcase
		end
	end

	// Take a new beat whenever the output register is free or draining
	assign cmd.ready = !rsp_valid_q || rsp.ready;
	assign cmd_fire  = cmd.valid && cmd.ready;

	assign ctrl.adv    = cmd_fire;
	assign ctrl.sample = (cmd.mode == MODE_SAMPLE);
	assign ctrl.clear  = (cmd.mode == MODE_CLEAR);

	// One lane per implemented line; lines beyond NUM_LINES never go pending
	for (genvar i = 0; i < LINE_W; i++) begin : g_lane
		if (i < NUM_LINES) begin : g_on
			eic_lane u_lane (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctrl     (ctrl),
				.sel      (port_select_q[SEL_W*i +: SEL_W]),
				.pins     ({cmd.port_d_pins[i], cmd.port_c_pins[i],
				            cmd.port_b_pins[i], cmd.port_a_pins[i]}),
				.rise_en  (rising_enable_q[i]),
				.fall_en  (falling_enable_q[i]),
				.clr      (cmd.clear_bits[i]),
				.pend_nxt (pend_nxt[i])
			);
		end else begin : g_off
			assign pend_nxt[i] = 1'b0;
		end
	end

	eic_merge u_merge (
		.pend (pend_nxt),
		.mask (interrupt_mask_q),
		.vec  (vec_nxt)
	);

	// Hold the response until taken; load the next one on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd_fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			pending_q <= pend_nxt;
			vec_q     <= vec_nxt;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.pending_flags = pending_q;
	assign rsp.irq_vectors   = vec_q;

endmodule

@@ sv/eic_checker.sv @@
// Port-level checks of the external interrupt edge controller and their bind.
module eic_checker import eic_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              cmd_valid,
	input logic              cmd_ready,
	input logic [MODE_W-1:0] cmd_mode,
	input logic [LINE_W-1:0] cmd_clear_bits,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic [LINE_W-1:0] rsp_pending_flags,
	input logic [VEC_W-1:0]  rsp_irq_vectors
);

	// stalled response beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pending_flags)
			&& $stable(rsp_irq_vectors))
		else $error("response beat changed while stalled");

	// every accepted command yields a response in the next cycle
	a_cmd_to_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> rsp_valid)
		else $error("no response after accepted command");

	// an empty output stage never backs up the command side
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> cmd_ready)
		else $error("command stalled with empty output");

	// a clear beat leaves none of its bits pending
	a_clear_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && cmd_mode == MODE_CLEAR
			|=> (rsp_pending_flags & $past(cmd_clear_bits)) == '0)
		else $error("cleared line still pending");

	// a vector only fires for pending lines of its group
	a_vec_pending: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((rsp_irq_vectors[4:0] & ~rsp_pending_flags[4:0]) == '0)
			&& (!rsp_irq_vectors[5] || (|rsp_pending_flags[9:5]))
			&& (!rsp_irq_vectors[6] || (|rsp_pending_flags[15:10])))
		else $error("vector raised without pending line");

endmodule

bind external_interrupt_edge_controller eic_checker u_eic_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.cmd_valid         (cmd.valid),
	.cmd_ready         (cmd.ready),
	.cmd_mode          (cmd.mode),
	.cmd_clear_bits    (cmd.clear_bits),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_pending_flags (rsp.pending_flags),
	.rsp_irq_vectors   (rsp.irq_vectors)
);

@@ verif/external_interrupt_edge_controller_tb.sv @@
// Self-checking testbench for the external interrupt edge controller.
`timescale 1ns / 100ps

module external_interrupt_edge_controller_tb;
	import eic_pkg::*;

	// Mode 3 has no code in the package; it behaves as a read
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam logic [LINE_W-1:0] LINE_MASK =
		(NUM_LINES_DEF >= LINE_W) ? {LINE_W{1'b1}} : LINE_W'((1 << NUM_LINES_DEF) - 1);
	localparam int NUM_PHASES      = 8;
	localparam int ITEMS_PER_PHASE = 88;
	localparam int MAX_REPORTED    = 10;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [LINE_W-1:0] pins_a;
		logic [LINE_W-1:0] pins_b;
		logic [LINE_W-1:0] pins_c;
		logic [LINE_W-1:0] pins_d;
		logic [LINE_W-1:0] clear_bits;
	} step_cmd_t;

	typedef struct packed {
		logic [LINE_W-1:0] pending;
		logic [VEC_W-1:0]  vectors;
	} line_report_t;

	// One row of the directed table: either a register write or a command beat
	typedef struct {
		bit                    is_write;
		logic [CFG_IDX_W-1:0]  reg_index;
		logic [CFG_DATA_W-1:0] reg_data;
		step_cmd_t             step;
		bit                    typed;
		line_report_t          want;
	} stim_row_t;

	logic clk;
	logic arst_n;

	eic_cfg_if cfg_ch ();
	eic_cmd_if cmd_ch ();
	eic_rsp_if rsp_ch ();

	external_interrupt_edge_controller DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	// Shadow copy of the block's registers and line state
	logic [PSEL_W-1:0] port_sel_shadow;
	logic [LINE_W-1:0] rise_en_shadow;
	logic [LINE_W-1:0] fall_en_shadow;
	logic [LINE_W-1:0] irq_mask_shadow;
	logic [LINE_W-1:0] last_levels;
	logic [LINE_W-1:0] pending_lines;

	line_report_t due_reports[$];
	stim_row_t    directed_rows[$];

	// Set by the sender for the beat it is offering; the watcher picks it up on accept
	bit           typed_on;
	line_report_t typed_report;

	bit        steady_phase;
	int        error_count;
	step_cmd_t held_pins;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard stop well past the slowest legal run
	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

	// Advance the shadow state by one command and return the report it produces
	function automatic line_report_t compute_line_report(step_cmd_t c);
		logic [LINE_W-1:0] ports[NUM_PORTS];
		logic [LINE_W-1:0] now_levels;
		logic [LINE_W-1:0] rises;
		logic [LINE_W-1:0] falls;
		logic [LINE_W-1:0] active;
		logic [SEL_W-1:0]  sel;
		line_report_t      r;
		ports[0] = c.pins_a;
		ports[1] = c.pins_b;
		ports[2] = c.pins_c;
		ports[3] = c.pins_d;
		if (c.mode == MODE_SAMPLE) begin
			for (int i = 0; i < LINE_W; i++) begin
				sel = port_sel_shadow[SEL_W*i +: SEL_W];
				now_levels[i] = ports[sel][i];
			end
			now_levels &= LINE_MASK;
			rises = now_levels & ~last_levels & rise_en_shadow;
			falls = ~now_levels & last_levels & fall_en_shadow;
			pending_lines = (pending_lines | rises | falls) & LINE_MASK;
			last_levels = now_levels;
		end else if (c.mode == MODE_CLEAR) begin
			pending_lines &= ~c.clear_bits & LINE_MASK;
		end
		active = pending_lines & irq_mask_shadow & LINE_MASK;
		r.pending = pending_lines;
		r.vectors = {|active[15:10], |active[9:5], active[4:0]};
		return r;
	endfunction

	task automatic flag_mismatch(string field, int unsigned want, int unsigned got);
		error_count++;
		if (error_count <= MAX_REPORTED)
			$display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $realtime, field, want, got);
	endtask

	// Watch every handshake at the rising edge: track register writes, predict
	// on each accepted command beat, and check each accepted response beat.
	always @(posedge clk) begin : watch_beats
		line_report_t want;
		line_report_t got;
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				case (cfg_ch.index)
					REG_PORT_SELECT:    port_sel_shadow = cfg_ch.data;
					REG_RISING_ENABLE:  rise_en_shadow  = cfg_ch.data[LINE_W-1:0];
					REG_FALLING_ENABLE: fall_en_shadow  = cfg_ch.data[LINE_W-1:0];
					REG_INTERRUPT_MASK: irq_mask_shadow = cfg_ch.data[LINE_W-1:0];
					default: ;
				endcase
			end
			if (cmd_ch.valid && cmd_ch.ready) begin
				want = compute_line_report({cmd_ch.mode, cmd_ch.port_a_pins, cmd_ch.port_b_pins,
					cmd_ch.port_c_pins, cmd_ch.port_d_pins, cmd_ch.clear_bits});
				// Directed rows with a hand-typed result override the shadow's answer
				if (typed_on)
					want = typed_report;
				due_reports.push_back(want);
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				got = {rsp_ch.pending_flags, rsp_ch.irq_vectors};
				if (due_reports.size() == 0) begin
					flag_mismatch("unexpected response beat", 0, 32'(got));
				end else begin
					want = due_reports.pop_front();
					if (got.pending !== want.pending)
						flag_mismatch("pending_flags", 32'(want.pending), 32'(got.pending));
					if (got.vectors !== want.vectors)
						flag_mismatch("irq_vectors", 32'(want.vectors), 32'(got.vectors));
				end
			end
		end
	end

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Response side: stall at random, except in steady phases
	initial begin : drive_rsp_ready
		int stall_left;
		stall_left = 0;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				rsp_ch.ready = 1'b0;
				stall_left--;
			end else begin
				rsp_ch.ready = 1'b1;
				if (!steady_phase && $urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	// Offer one command beat and hold it until accepted; return at the next falling edge
	task automatic send_command(step_cmd_t c, bit typed, line_report_t want);
		cmd_ch.mode        = c.mode;
		cmd_ch.port_a_pins = c.pins_a;
		cmd_ch.port_b_pins = c.pins_b;
		cmd_ch.port_c_pins = c.pins_c;
		cmd_ch.port_d_pins = c.pins_d;
		cmd_ch.clear_bits  = c.clear_bits;
		typed_on     = typed;
		typed_report = want;
		cmd_ch.valid = 1'b1;
		do @(posedge clk); while (!cmd_ch.ready);
		@(negedge clk);
	endtask

	// Drop valid for a random gap; keep it high when no gap is drawn
	task automatic idle_sender();
		int gap;
		gap = steady_phase ? 0 : pick_gap();
		if (gap > 0) begin
			cmd_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Stop sending and wait for every outstanding response to be taken
	task automatic drain_to_idle();
		cmd_ch.valid = 1'b0;
		while (due_reports.size() != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_ch.index = idx;
		cfg_ch.data  = data;
		cfg_ch.valid = 1'b1;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	function automatic void add_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		stim_row_t row;
		row          = '{default: '0};
		row.is_write = 1'b1;
		row.reg_index = idx;
		row.reg_data  = data;
		directed_rows.push_back(row);
	endfunction

	function automatic void add_step(logic [MODE_W-1:0] mode, logic [LINE_W-1:0] a,
		logic [LINE_W-1:0] b, logic [LINE_W-1:0] c, logic [LINE_W-1:0] d,
		logic [LINE_W-1:0] clr, bit typed, logic [LINE_W-1:0] pend, logic [VEC_W-1:0] vec);
		stim_row_t row;
		row       = '{default: '0};
		row.step  = {mode, a, b, c, d, clr};
		row.typed = typed;
		row.want  = {pend, vec};
		directed_rows.push_back(row);
	endfunction

	// Register value: zero, all ones, or random (upper data bits toggle too)
	function automatic logic [CFG_DATA_W-1:0] pick_reg_value(logic [CFG_DATA_W-1:0] all_ones);
		case ($urandom_range(0, 5))
			0: return '0;
			1: return all_ones;
			default: return $urandom;
		endcase
	endfunction

	// Random command: mostly samples, with pins that repeat, flip a bit, or change freely
	function automatic step_cmd_t roll_command();
		step_cmd_t c;
		int        r;
		c = held_pins;
		r = $urandom_range(0, 99);
		if (r < 60)
			c.mode = MODE_SAMPLE;
		else if (r < 80)
			c.mode = MODE_CLEAR;
		else if (r < 93)
			c.mode = MODE_READ;
		else
			c.mode = MODE_UNUSED;
		case ($urandom_range(0, 4))
			0: ;
			1: begin
				c.pins_a ^= LINE_W'(1) << $urandom_range(0, LINE_W-1);
				c.pins_b ^= LINE_W'(1) << $urandom_range(0, LINE_W-1);
				c.pins_c ^= LINE_W'(1) << $urandom_range(0, LINE_W-1);
				c.pins_d ^= LINE_W'(1) << $urandom_range(0, LINE_W-1);
			end
			default: begin
				c.pins_a = LINE_W'($urandom);
				c.pins_b = LINE_W'($urandom);
				c.pins_c = LINE_W'($urandom);
				c.pins_d = LINE_W'($urandom);
			end
		endcase
		case ($urandom_range(0, 3))
			0: c.clear_bits = LINE_W'($urandom);
			1: c.clear_bits = LINE_W'(1) << $urandom_range(0, LINE_W-1);
			2: c.clear_bits = '1;
			default: c.clear_bits = LINE_W'($urandom & $urandom);
		endcase
		held_pins = c;
		return c;
	endfunction

	initial begin : run_stimulus
		step_cmd_t             c;
		logic [CFG_DATA_W-1:0] sel_val;
		logic [CFG_DATA_W-1:0] rise_val;
		logic [CFG_DATA_W-1:0] fall_val;
		logic [CFG_DATA_W-1:0] mask_val;

		// Drive every input to a known value before reset releases
		arst_n             = 1'b0;
		cfg_ch.valid       = 1'b0;
		cfg_ch.index       = '0;
		cfg_ch.data        = '0;
		cmd_ch.valid       = 1'b0;
		cmd_ch.mode        = MODE_READ;
		cmd_ch.port_a_pins = '0;
		cmd_ch.port_b_pins = '0;
		cmd_ch.port_c_pins = '0;
		cmd_ch.port_d_pins = '0;
		cmd_ch.clear_bits  = '0;
		typed_on           = 1'b0;
		typed_report       = '0;
		steady_phase       = 1'b0;
		error_count        = 0;
		held_pins          = '0;
		port_sel_shadow    = '0;
		rise_en_shadow     = '0;
		fall_en_shadow     = '0;
		irq_mask_shadow    = '0;
		last_levels        = '0;
		pending_lines      = '0;

		// Directed table. Typed rows carry results read straight off the rules;
		// the rest are left to the shadow predictor.
		// Right after reset nothing is pending
		add_step(MODE_READ, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, 16'h0000, 7'h00);
		// All lines on port A, rising edges only, all vectors unmasked
		add_write(REG_RISING_ENABLE, 32'h0000_FFFF);
		add_write(REG_INTERRUPT_MASK, 32'h0000_FFFF);
		// First tick after reset: every high line counts as a rising edge
		add_step(MODE_SAMPLE, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, 16'hFFFF, 7'h7F);
		// Falling edges are disabled, other ports are not selected
		add_step(MODE_SAMPLE, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 1, 16'hFFFF, 7'h7F);
		// Clear everything; pins are ignored outside a sample
		add_step(MODE_CLEAR, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 1, 16'h0000, 7'h00);
		// Unused mode acts as a read: no sample, no clear
		add_step(MODE_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 16'h0000, 7'h00);
		// Port D everywhere, falling edges only, everything masked
		add_write(REG_RISING_ENABLE, 32'h0000_0000);
		add_write(REG_FALLING_ENABLE, 32'h0000_FFFF);
		add_write(REG_PORT_SELECT, 32'hFFFF_FFFF);
		add_write(REG_INTERRUPT_MASK, 32'h0000_0000);
		add_step(MODE_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 1, 16'h0000, 7'h00);
		add_step(MODE_SAMPLE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 1, 16'hFFFF, 7'h00);
		add_step(MODE_CLEAR, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h00FF, 1, 16'hFF00, 7'h00);
		// Clear bits outside a clear access do nothing
		add_step(MODE_READ, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 1, 16'hFF00, 7'h00);
		// Unmask: lines 8..9 hit the shared 5..9 vector, 10..15 the upper one
		add_write(REG_INTERRUPT_MASK, 32'h0000_FFFF);
		add_step(MODE_READ, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, 16'hFF00, 7'h60);
		// Port B, both edges enabled
		add_write(REG_PORT_SELECT, 32'h5555_5555);
		add_write(REG_RISING_ENABLE, 32'h0000_FFFF);
		add_step(MODE_SAMPLE, 16'h5555, 16'hAAAA, 16'h5555, 16'h5555, 16'h0000, 1, 16'hFFAA, 7'h6A);
		add_step(MODE_CLEAR, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 1, 16'h0000, 7'h00);
		add_step(MODE_SAMPLE, 16'hAAAA, 16'h5555, 16'hAAAA, 16'hAAAA, 16'h0000, 1, 16'hFFFF, 7'h7F);
		add_step(MODE_CLEAR, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 1, 16'h0000, 7'h00);
		// Selector moved to port C: the new port's level against the kept one is an edge
		add_write(REG_PORT_SELECT, 32'hAAAA_AAAA);
		add_step(MODE_SAMPLE, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 1, 16'h5555, 7'h75);
		add_step(MODE_CLEAR, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFE, 1, 16'h0001, 7'h01);
		add_step(MODE_CLEAR, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0001, 1, 16'h0000, 7'h00);
		// Mixed selectors and a single unmasked line: leave these to the predictor
		add_write(REG_PORT_SELECT, 32'h1B1B_1B1B);
		add_write(REG_INTERRUPT_MASK, 32'h0000_0400);
		add_step(MODE_SAMPLE, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 16'h0000, 0, '0, '0);
		add_step(MODE_SAMPLE, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 0, '0, '0);
		add_step(MODE_SAMPLE, 16'h0F0F, 16'hF0F0, 16'h3C3C, 16'hC3C3, 16'h0000, 0, '0, '0);
		add_step(MODE_CLEAR, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h8421, 0, '0, '0);
		add_step(MODE_READ, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, '0, '0);

		// Hold reset, then release it at a falling edge
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_write) begin
				drain_to_idle();
				write_reg(directed_rows[i].reg_index, directed_rows[i].reg_data);
			end else begin
				send_command(directed_rows[i].step, directed_rows[i].typed, directed_rows[i].want);
				idle_sender();
			end
		end

		// Random phases: drain, rewrite all four registers, then a batch of commands.
		// The first two phases pin the registers to their extremes.
		typed_on = 1'b0;
		for (int p = 0; p < NUM_PHASES; p++) begin
			drain_to_idle();
			if (p == 0) begin
				sel_val  = 32'hFFFF_FFFF;
				rise_val = 32'h0000_FFFF;
				fall_val = 32'h0000_FFFF;
				mask_val = 32'h0000_FFFF;
			end else if (p == 1) begin
				sel_val  = '0;
				rise_val = '0;
				fall_val = '0;
				mask_val = '0;
			end else begin
				sel_val  = pick_reg_value(32'hFFFF_FFFF);
				rise_val = pick_reg_value(32'h0000_FFFF);
				fall_val = pick_reg_value(32'h0000_FFFF);
				mask_val = pick_reg_value(32'h0000_FFFF);
			end
			write_reg(REG_PORT_SELECT, sel_val);
			write_reg(REG_RISING_ENABLE, rise_val);
			write_reg(REG_FALLING_ENABLE, fall_val);
			write_reg(REG_INTERRUPT_MASK, mask_val);
			// Every third phase runs back to back with no idling on either side
			steady_phase = (p % 3 == 2);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				c = roll_command();
				send_command(c, 1'b0, '0);
				idle_sender();
			end
		end

		// Wait out the last responses and the pipeline latency
		cmd_ch.valid = 1'b0;
		steady_phase = 1'b0;
		while (due_reports.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
